@@ design/tpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tpp_pkg;
  localparam int unsigned TickRateDefault = 20000;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_ACCEL    = 3'd0,
    CFG_DOWN_ACCEL  = 3'd1,
    CFG_RATED_SPEED = 3'd2,
    CFG_BRAKE_BAND  = 3'd3,
    CFG_STOP_FACTOR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] position;
    logic [31:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_position;
    logic [31:0] out_velocity;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;
endpackage
`default_nettype wire

@@ design/tpp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface tpp_in_if;
  logic valid;
  logic ready;
  tpp_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpp_out_if;
  logic valid;
  logic ready;
  tpp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpp_cfg_if;
  logic valid;
  logic ready;
  tpp_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/tpp_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial signed division by a constant tick rate, truncating toward zero.
// The magnitude of the dividend is shifted in one bit per cycle (restoring).
// The result is ready when done is raised, once all 34 dividend bits have been
// shifted in.
module tpp_divider #(
  parameter int unsigned TickRate = tpp_pkg::TickRateDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [33:0] dividend_i,
  output logic                    done_o,
  output logic signed [33:0]      quot_o,
  output logic signed [33:0]      rem_o
);
  import tpp_pkg::*;
  localparam int unsigned RemW = $clog2(TickRate) + 1;
  localparam logic [RemW:0] Divisor = (RemW + 1)'(TickRate);

  logic [33:0]   mag_q, mag_d;
  logic [RemW:0] rem_q, rem_d;
  logic          neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [RemW:0] trial;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[RemW-1:0], mag_q[33]};
    if (start_i) begin
      neg_d  = dividend_i[33];
      mag_d  = dividend_i[33] ? 34'(-dividend_i) : dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != 6'd0) begin
        if (trial >= Divisor) begin
          rem_d = trial - Divisor;
          mag_d = {mag_q[32:0], 1'b1};
        end else begin
          rem_d = trial;
          mag_d = {mag_q[32:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd0);
  assign quot_o = neg_q ? 34'(-mag_q) : mag_q;
  assign rem_o  = neg_q ? -34'(rem_q) : 34'(rem_q);
endmodule
`default_nettype wire

@@ design/trapezoid_position_profiler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// in_ch     sink       cmd, position, velocity
// out_ch    source     out_position, out_velocity
// cfg_ch    sink       register index, write data
// A load result is offered in the cycle after its transaction. A step result
// is offered after shift-add squaring, a shift-add multiply by stop_factor, a
// decision state, two bit-serial divisions by the tick rate and an output
// state; the velocity division is skipped when the velocity holds or rests at
// the goal. Reset is asynchronous, active low.
// A transaction is taken only when idle and the previous result has been taken.
module trapezoid_position_profiler #(
  parameter int unsigned TickRate = tpp_pkg::TickRateDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tpp_in_if.sink   in_ch,
  tpp_out_if.source out_ch,
  tpp_cfg_if.sink  cfg_ch
);
  import tpp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQR  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_VDIV = 7'b0010000,
    S_PDIV = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [30:0] up_q, down_q, rated_q, bb_q;
  logic [31:0] sf_q;
  logic signed [31:0] pos_q, vel_q, vrem_q, prem_q;
  logic signed [31:0] goal_q;

  // Serial multiply operands.
  logic [63:0] acc_q;
  logic [63:0] mcand_q;
  logic [31:0] mplier_q;
  logic [5:0]  mcnt_q;
  logic [95:0] prod_q;

  logic signed [32:0] dist_d;

  logic out_valid_q;
  out_item_t out_q;

  logic div_start;
  logic signed [33:0] div_dividend, div_quot, div_rem;
  logic div_done;

  tpp_divider #(.TickRate(TickRate)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_q == S_IDLE) && !out_valid_q;
  assign out_ch.valid = out_valid_q;
  assign out_ch.payload = out_q;

  wire in_fire = in_ch.valid && in_ch.ready;
  assign dist_d = 33'(goal_q) - 33'(pos_q);

  logic [31:0] vmag;
  assign vmag = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);

  // Decision for a step, made once the stopping distance is known.
  logic signed [33:0] acc_sel;
  logic               rest, skip_accel, keep_v, slow_down, speed_up;
  logic [32:0] dmag;
  logic pos_dir, toward;
  always_comb begin
    acc_sel    = '0;
    rest       = 1'b0;
    keep_v     = 1'b0;
    skip_accel = 1'b0;
    slow_down  = 1'b0;
    speed_up   = 1'b0;
    pos_dir    = !vel_q[31];
    toward     = (!dist_d[32]) == pos_dir;
    dmag       = dist_d[32] ? 33'(-dist_d) : 33'(dist_d);
    if (dist_d == '0) begin
      if (vmag <= {1'b0, bb_q}) begin
        rest = 1'b1;
      end else begin
        slow_down = 1'b1;
        acc_sel   = pos_dir ? -34'(down_q) : 34'(down_q);
      end
    end else if (vel_q == '0) begin
      acc_sel = dist_d[32] ? -34'(up_q) : 34'(up_q);
    end else if (toward && vmag <= {1'b0, rated_q}
                 && {31'd0, dmag} > prod_q[95:32]) begin
      if (vmag < {1'b0, rated_q}) begin
        speed_up = 1'b1;
        acc_sel  = pos_dir ? 34'(up_q) : -34'(up_q);
      end else begin
        keep_v = 1'b1;
      end
    end else begin
      slow_down = 1'b1;
      acc_sel   = pos_dir ? -34'(down_q) : 34'(down_q);
    end
    skip_accel = rest || keep_v;
  end

  // Clamping after the velocity division.
  logic signed [33:0] v_sum;
  logic signed [33:0] v_fin;
  logic signed [33:0] rated_s;
  logic               v_clamp;
  assign v_sum   = 34'(vel_q) + div_quot;
  assign rated_s = 34'(rated_q);
  always_comb begin
    v_fin   = v_sum;
    v_clamp = 1'b0;
    if (slow_down) begin
      // Slowing down: stop at zero crossing.
      if (!vel_q[31] ? (v_sum <= 34'sd0) : (v_sum >= 34'sd0)) begin
        v_fin = '0;
        v_clamp = 1'b1;
      end
    end else if (speed_up) begin
      if (!vel_q[31] ? (v_sum >= rated_s) : (v_sum <= -rated_s)) begin
        v_fin = !vel_q[31] ? rated_s : -rated_s;
        v_clamp = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = '0;
    unique case (state_q)
      S_IDLE: if (in_fire && !in_ch.payload.cmd) state_d = S_SQR;
      S_SQR:  if (mcnt_q == 6'd0) state_d = S_MUL;
      S_MUL:  if (mcnt_q == 6'd0) state_d = S_DEC;
      S_DEC: begin
        if (skip_accel) begin
          state_d = S_PDIV;
          div_start = 1'b1;
          div_dividend = rest ? 34'(0) : 34'(prem_q) + 34'(vel_q);
        end else begin
          state_d = S_VDIV;
          div_start = 1'b1;
          div_dividend = 34'(vrem_q) + acc_sel;
        end
      end
      S_VDIV: if (div_done) begin
        state_d = S_PDIV;
        div_start = 1'b1;
        div_dividend = 34'(prem_q) + 34'($signed(v_fin[31:0]));
      end
      S_PDIV: if (div_done) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      up_q    <= 31'd1000000;
      down_q  <= 31'd1000000;
      rated_q <= 31'd1000000;
      bb_q    <= 31'd1000;
      sf_q    <= 32'd4295;
      pos_q   <= '0;
      vel_q   <= '0;
      vrem_q  <= '0;
      prem_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.payload.index)
          CFG_UP_ACCEL:    up_q    <= cfg_ch.payload.data[30:0];
          CFG_DOWN_ACCEL:  down_q  <= cfg_ch.payload.data[30:0];
          CFG_RATED_SPEED: rated_q <= cfg_ch.payload.data[30:0];
          CFG_BRAKE_BAND:  bb_q    <= cfg_ch.payload.data[30:0];
          CFG_STOP_FACTOR: sf_q    <= cfg_ch.payload.data;
          default: ;
        endcase
      end
      if (in_fire && in_ch.payload.cmd) begin
        pos_q  <= in_ch.payload.position;
        vel_q  <= in_ch.payload.velocity;
        vrem_q <= '0;
        prem_q <= '0;
        out_q  <= '{in_ch.payload.position, in_ch.payload.velocity};
        out_valid_q <= 1'b1;
      end
      if (state_q == S_DEC && rest) begin
        vel_q  <= '0;
        vrem_q <= '0;
        prem_q <= '0;
      end
      if (state_q == S_VDIV && div_done) begin
        vel_q  <= v_fin[31:0];
        vrem_q <= v_clamp ? 32'sd0 : div_rem[31:0];
      end
      if (state_q == S_PDIV && div_done) begin
        pos_q  <= 32'(34'(pos_q) + div_quot);
        prem_q <= div_rem[31:0];
      end
      if (state_q == S_DONE) begin
        out_q <= '{pos_q, vel_q};
        out_valid_q <= 1'b1;
      end
    end
  end

  // Shift-add multiplier: vmag*vmag, then the square times stop_factor.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      goal_q <= in_ch.payload.position;
    end
    unique case (state_q)
      S_IDLE: begin
        mcnt_q   <= 6'd32;
        acc_q    <= '0;
        mcand_q  <= {32'd0, vmag};
        mplier_q <= vmag;
      end
      S_SQR: begin
        if (mcnt_q != 6'd0) begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= {mcand_q[62:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[31:1]};
          mcnt_q   <= mcnt_q - 6'd1;
        end else begin
          mcnt_q   <= 6'd32;
          prod_q   <= '0;
          mcand_q  <= acc_q;
          mplier_q <= sf_q;
        end
      end
      S_MUL: begin
        if (mcnt_q != 6'd0) begin
          // Product is accumulated from the top: shift right and add.
          if (mplier_q[0]) prod_q <= {1'b0, prod_q[95:1]} + {1'b0, mcand_q, 31'd0};
          else prod_q <= {1'b0, prod_q[95:1]};
          mplier_q <= {1'b0, mplier_q[31:1]};
          mcnt_q   <= mcnt_q - 6'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q) else $error("result lost");
`endif
endmodule
`default_nettype wire
